FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tlec_pkg.sv
`default_nettype none

package tlec_pkg;

    // fixed field widths
    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned SET_FIELD_W = 4;
    localparam int unsigned TAG_W       = ADDR_W - SET_FIELD_W;
    localparam int unsigned CNT_W       = 32;

    // default geometry
    localparam int unsigned DEF_NEAR_SETS = 16;
    localparam int unsigned DEF_FAR_SETS  = 16;
    localparam int unsigned DEF_FAR_WAYS  = 8;

    typedef enum logic {
        FUNC_READ  = 1'b0,
        FUNC_WRITE = 1'b1
    } t_func;

    typedef struct packed {
        t_func              func;
        logic [ADDR_W-1:0]  address;
    } t_req;

    typedef struct packed {
        logic               l1_hit;
        logic               l2_hit;
        logic [CNT_W-1:0]   l1_access_count;
        logic [CNT_W-1:0]   l1_miss_count;
        logic [CNT_W-1:0]   l2_access_count;
        logic [CNT_W-1:0]   l2_miss_count;
    } t_resp;

    // lookup context handed to the far-level update logic
    typedef struct packed {
        logic l1_hit;
        logic is_write;
        logic victim_valid;
    } t_far_ctl;

    // decisions coming back from the far-level update logic
    typedef struct packed {
        logic l2_hit;
        logic near_fill;
        logic row_we;
    } t_far_res;

    // Set field modulo a set count, by repeated subtraction (narrow value).
    function automatic logic [7:0] set_mod(input logic [SET_FIELD_W-1:0] f,
                                           input logic [8:0] m);
        logic [8:0] v;
        v = 9'(f);
        for (int i = 0; i < 8; i++) begin
            if (v >= m) begin
                v = v - m;
            end
        end
        return v[7:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/two_level_exclusive_cache_tags.sv
`default_nettype none

// Tag and LRU bookkeeping for a direct-mapped L1 in front of an exclusive
// set-associative L2. One request (read or write to a 32-bit word address)
// yields one response with the L1/L2 hit flags and four wrapping counters.
// A request is taken only while the block is idle: the edge that accepts it
// launches reads of the L1 tag memory and the L2 set row (tags and ranks of
// all ways), and in the execute state that then follows the lookup, LRU update
// and write-back of both memories happen while the response register loads.
// While the response register stays full and
// stalled, the block holds in its write-back cycle. Valid bits for L1 sets
// and L2 rows are flip-flops cleared by reset; no clearing pass is needed.
module two_level_exclusive_cache_tags
    import tlec_pkg::*;
#(
    parameter int unsigned NEAR_SETS = DEF_NEAR_SETS,
    parameter int unsigned FAR_SETS  = DEF_FAR_SETS,
    parameter int unsigned FAR_WAYS  = DEF_FAR_WAYS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_req_valid,
    output logic       o_req_stall,
    input  wire t_req  i_req,
    output logic       o_resp_valid,
    input  wire logic  i_resp_stall,
    output t_resp      o_resp
);

`include "assert_macros.svh"

    localparam int unsigned NS_W   = $clog2(NEAR_SETS);
    localparam int unsigned FS_W   = $clog2(FAR_SETS);
    localparam int unsigned RANK_W = $clog2(FAR_WAYS) + 1;
    localparam int unsigned ROW_W  = FAR_WAYS * (TAG_W + RANK_W);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state              r_state, n_state;
    logic                r_resp_valid;
    t_resp               r_resp;
    logic [NEAR_SETS-1:0] r_near_vld;
    logic [FAR_SETS-1:0] r_far_vld;
    logic [CNT_W-1:0]    r_l1_acc, r_l1_miss, r_l2_acc, r_l2_miss;
    logic [CNT_W-1:0]    n_l1_acc, n_l1_miss, n_l2_acc, n_l2_miss;

    t_func               r_func;
    logic [TAG_W-1:0]    r_tag;
    logic [NS_W-1:0]     r_ns;
    logic [FS_W-1:0]     r_fs;

    logic [NS_W-1:0]     req_ns;
    logic [FS_W-1:0]     req_fs;
    logic                w_accept;
    logic                w_load;
    logic [TAG_W-1:0]    near_rdata;
    logic [ROW_W-1:0]    far_rdata;
    logic [ROW_W-1:0]    far_wdata;
    logic                near_we;
    logic                far_we;
    logic                l1_hit;
    t_far_ctl            far_ctl;
    t_far_res            far_res;

    // handshake
    assign o_req_stall = (r_state != S_IDLE);
    assign w_accept    = i_req_valid && !o_req_stall;
    assign w_load      = (r_state == S_EXEC) && (!r_resp_valid || !i_resp_stall);

    // set selection from the low address bits
    assign req_ns = NS_W'(set_mod(i_req.address[SET_FIELD_W-1:0], 9'(NEAR_SETS)));
    assign req_fs = FS_W'(set_mod(i_req.address[SET_FIELD_W-1:0], 9'(FAR_SETS)));

    // request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= i_req.func;
            r_tag  <= i_req.address[ADDR_W-1:SET_FIELD_W];
            r_ns   <= req_ns;
            r_fs   <= req_fs;
        end
    end

    // L1 tag memory
    tlec_ram #(
        .WIDTH (TAG_W),
        .DEPTH (NEAR_SETS)
    ) u_near_ram (
        .i_clk   (i_clk),
        .i_we    (near_we),
        .i_waddr (r_ns),
        .i_wdata (r_tag),
        .i_re    (w_accept),
        .i_raddr (req_ns),
        .o_rdata (near_rdata)
    );

    // L2 set rows: rank and tag of every way
    tlec_ram #(
        .WIDTH (ROW_W),
        .DEPTH (FAR_SETS)
    ) u_far_ram (
        .i_clk   (i_clk),
        .i_we    (far_we),
        .i_waddr (r_fs),
        .i_wdata (far_wdata),
        .i_re    (w_accept),
        .i_raddr (req_fs),
        .o_rdata (far_rdata)
    );

    // L1 lookup; the current L1 line is also the L2 victim
    assign l1_hit               = r_near_vld[r_ns] && (near_rdata == r_tag);
    assign far_ctl.l1_hit       = l1_hit;
    assign far_ctl.is_write     = (r_func == FUNC_WRITE);
    assign far_ctl.victim_valid = r_near_vld[r_ns];

    tlec_far #(
        .FAR_WAYS (FAR_WAYS)
    ) u_far (
        .i_ctl        (far_ctl),
        .i_tag        (r_tag),
        .i_victim_tag (near_rdata),
        .i_row_valid  (r_far_vld[r_fs]),
        .i_row        (far_rdata),
        .o_res        (far_res),
        .o_row        (far_wdata)
    );

    assign near_we = w_load && far_res.near_fill;
    assign far_we  = w_load && far_res.row_we;

    // statistics
    always_comb begin
        n_l1_acc  = r_l1_acc + CNT_W'(1);
        n_l1_miss = r_l1_miss + CNT_W'(!l1_hit);
        n_l2_acc  = r_l2_acc + CNT_W'(!l1_hit);
        n_l2_miss = r_l2_miss + CNT_W'(!l1_hit && !far_res.l2_hit);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, valid bits, counters and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_resp_valid <= 1'b0;
            r_near_vld   <= '0;
            r_far_vld    <= '0;
            r_l1_acc     <= '0;
            r_l1_miss    <= '0;
            r_l2_acc     <= '0;
            r_l2_miss    <= '0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_resp_valid           <= 1'b1;
                r_resp.l1_hit          <= l1_hit;
                r_resp.l2_hit          <= far_res.l2_hit;
                r_resp.l1_access_count <= n_l1_acc;
                r_resp.l1_miss_count   <= n_l1_miss;
                r_resp.l2_access_count <= n_l2_acc;
                r_resp.l2_miss_count   <= n_l2_miss;
                r_l1_acc               <= n_l1_acc;
                r_l1_miss              <= n_l1_miss;
                r_l2_acc               <= n_l2_acc;
                r_l2_miss              <= n_l2_miss;
                if (near_we) begin
                    r_near_vld[r_ns] <= 1'b1;
                end
                if (far_we) begin
                    r_far_vld[r_fs] <= 1'b1;
                end
            end else if (!i_resp_stall) begin
                r_resp_valid <= 1'b0;
            end
        end
    end

    assign o_resp_valid = r_resp_valid;
    assign o_resp       = r_resp;

    // checks
    `ASSERT_IMPL(ap_hits_exclusive, i_clk, i_rst_n, o_resp_valid, !(o_resp.l1_hit && o_resp.l2_hit), "both L1 and L2 hit reported")
    `ASSERT_IMPL(ap_miss_is_l2_access, i_clk, i_rst_n, 1'b1, r_l1_miss == r_l2_acc, "L1 miss count differs from L2 access count")
    `ASSERT_NEXT(ap_cnt_hold, i_clk, i_rst_n, !w_load, $stable(r_l1_acc), "access counter moved without a response")
    `ASSERT_IMPL(ap_l2hit_fills_l1, i_clk, i_rst_n, w_load && far_res.l2_hit, near_we, "L2 hit did not move the line into L1")
    `ASSERT_NEXT(ap_accept_exec, i_clk, i_rst_n, w_accept, r_state == S_EXEC, "accepted request not in write-back")

endmodule

`default_nettype wire

FILE: rtl/tlec_ram.sv
`default_nettype none

module tlec_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire logic [WIDTH-1:0]          i_wdata,
    input  wire logic                      i_re,
    input  wire logic [$clog2(DEPTH)-1:0]  i_raddr,
    output logic      [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port; read data holds without a read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/tlec_far.sv
`default_nettype none

module tlec_far
    import tlec_pkg::*;
#(
    parameter int unsigned FAR_WAYS = DEF_FAR_WAYS
) (
    input  wire t_far_ctl                                              i_ctl,
    input  wire logic [TAG_W-1:0]                                      i_tag,
    input  wire logic [TAG_W-1:0]                                      i_victim_tag,
    input  wire logic                                                  i_row_valid,
    input  wire logic [FAR_WAYS*(TAG_W+$clog2(FAR_WAYS)+1)-1:0]        i_row,
    output t_far_res                                                   o_res,
    output logic      [FAR_WAYS*(TAG_W+$clog2(FAR_WAYS)+1)-1:0]        o_row
);

    localparam int unsigned RANK_W  = $clog2(FAR_WAYS) + 1;
    localparam int unsigned ENTRY_W = TAG_W + RANK_W;
    localparam int unsigned WAY_W   = $clog2(FAR_WAYS);
    localparam logic signed [RANK_W-1:0] RANK_EMPTY = '1;
    localparam logic signed [RANK_W-1:0] RANK_TOP   = RANK_W'(FAR_WAYS - 1);
    localparam logic signed [RANK_W-1:0] RANK_ONE   = RANK_W'(1);

    logic signed [RANK_W-1:0] rank_in  [FAR_WAYS];
    logic signed [RANK_W-1:0] rank_hit [FAR_WAYS];
    logic signed [RANK_W-1:0] rank_out [FAR_WAYS];
    logic        [TAG_W-1:0]  tag_in   [FAR_WAYS];
    logic        [TAG_W-1:0]  tag_out  [FAR_WAYS];
    logic        [FAR_WAYS-1:0] hit_vec;
    logic        [WAY_W-1:0]  hit_way;
    logic        [WAY_W-1:0]  pick_way;
    logic signed [RANK_W-1:0] old_rank;
    logic                     l2_hit;
    logic                     fill;
    logic                     insert;

    // unpack the row; a row never written reads as all ways empty
    always_comb begin
        for (int w = 0; w < FAR_WAYS; w++) begin
            tag_in[w]  = i_row[w*ENTRY_W +: TAG_W];
            rank_in[w] = i_row_valid ? i_row[w*ENTRY_W+TAG_W +: RANK_W] : RANK_EMPTY;
            hit_vec[w] = (rank_in[w] != RANK_EMPTY) && (tag_in[w] == i_tag);
        end
    end

    // first hitting way
    always_comb begin
        hit_way = '0;
        for (int w = FAR_WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_way = WAY_W'(w);
            end
        end
    end

    assign l2_hit   = !i_ctl.l1_hit && (|hit_vec);
    assign old_rank = rank_in[hit_way];
    assign fill     = !i_ctl.l1_hit && (l2_hit || (i_ctl.is_write == 1'b0));
    assign insert   = fill && i_ctl.victim_valid;

    // hit removal: way goes empty, older-than-it ways move up by one rank
    always_comb begin
        for (int w = 0; w < FAR_WAYS; w++) begin
            rank_hit[w] = rank_in[w];
            if (l2_hit) begin
                if (WAY_W'(w) == hit_way) begin
                    rank_hit[w] = RANK_EMPTY;
                end else if ((rank_in[w] != RANK_EMPTY) && (rank_in[w] < old_rank)) begin
                    rank_hit[w] = rank_in[w] + RANK_ONE;
                end
            end
        end
    end

    // victim slot: first empty or least-recent way, else way 0
    always_comb begin
        pick_way = '0;
        for (int w = FAR_WAYS - 1; w >= 0; w--) begin
            if ((rank_hit[w] == RANK_EMPTY) || (rank_hit[w] == '0)) begin
                pick_way = WAY_W'(w);
            end
        end
    end

    // victim insertion at the top rank, other ways ranked above zero age down
    always_comb begin
        for (int w = 0; w < FAR_WAYS; w++) begin
            rank_out[w] = rank_hit[w];
            tag_out[w]  = tag_in[w];
            if (insert) begin
                if (WAY_W'(w) == pick_way) begin
                    rank_out[w] = RANK_TOP;
                    tag_out[w]  = i_victim_tag;
                end else if (rank_hit[w] > 0) begin
                    rank_out[w] = rank_hit[w] - RANK_ONE;
                end
            end
            o_row[w*ENTRY_W +: ENTRY_W] = {rank_out[w], tag_out[w]};
        end
    end

    assign o_res.l2_hit    = l2_hit;
    assign o_res.near_fill = fill;
    assign o_res.row_we    = l2_hit || insert;

endmodule

`default_nettype wire
